/* rtl/fbcd_pkg.sv */
// fbcd_pkg: shared types and constants of the foot bumper collision detector
// no dependencies; used by fbcd_update and the top level by scoped names

package fbcd_pkg;

    // sequencer states; code 3 is unused and behaves as wait
    typedef enum logic [1:0] {
        SEQ_WAIT  = 2'd0,
        SEQ_ONCE  = 2'd1,
        SEQ_TWICE = 2'd2
    } t_seq_state;

    // decoded bumper side; bit 0 is the left foot, bit 1 the right foot
    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2,
        SIDE_BOTH  = 2'd3
    } t_side;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned SWITCH_N = 4;
    localparam int unsigned CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_STATE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COLLISION = 1'b1;

    localparam logic [HOLD_W-1:0] HOLD_STATE_RST     = 16'd300;
    localparam logic [HOLD_W-1:0] HOLD_COLLISION_RST = 16'd1000;

    typedef struct packed {
        t_seq_state        seq;
        t_side             side;
        t_side             prev_side;
        logic [TIME_W-1:0] side_time;
        logic [TIME_W-1:0] begin_time;
        logic [TIME_W-1:0] last_time;
    } t_state;

    typedef struct packed {
        logic              result_valid;
        logic              collision;
        logic [TIME_W-1:0] collision_time_ms;
    } t_result;

endpackage

/* rtl/fbcd_update.sv */
// fbcd_update: one-sample state update and result of the collision detector
// depends on fbcd_pkg (state and result structs, side and sequencer codes)

module fbcd_update (
    input  fbcd_pkg::t_state                   i_state,
    input  logic                               i_left,
    input  logic                               i_right,
    input  logic                               i_damaged,
    input  logic [fbcd_pkg::TIME_W-1:0]        i_now,
    input  logic [fbcd_pkg::HOLD_W-1:0]        i_hold_state,
    input  logic [fbcd_pkg::HOLD_W-1:0]        i_hold_collision,
    output fbcd_pkg::t_state                   o_state,
    output fbcd_pkg::t_result                  o_result
);

    fbcd_pkg::t_side             side;
    logic [fbcd_pkg::TIME_W-1:0] side_time;
    logic [fbcd_pkg::TIME_W-1:0] seq_age;
    logic [fbcd_pkg::TIME_W-1:0] new_age;
    logic [fbcd_pkg::TIME_W-1:0] hold_state_ext;
    logic                        other_foot;
    fbcd_pkg::t_state            upd;

    assign hold_state_ext = {{(fbcd_pkg::TIME_W-fbcd_pkg::HOLD_W){1'b0}}, i_hold_state};
    assign seq_age        = i_now - i_state.begin_time;

    // sticky side decode
    always_comb begin
        side      = i_state.side;
        side_time = i_state.side_time;
        if (i_left || i_right) begin
            side      = fbcd_pkg::t_side'({i_right, i_left});
            side_time = i_now;
        end
    end

    // a bump on the other foot, or on both, inside the window
    assign other_foot = (seq_age < hold_state_ext)
                        && (i_state.prev_side != fbcd_pkg::SIDE_NONE)
                        && (side != fbcd_pkg::SIDE_NONE)
                        && !((i_state.prev_side == side) && (side != fbcd_pkg::SIDE_BOTH));

    always_comb begin
        upd           = i_state;
        upd.side      = side;
        upd.side_time = side_time;
        case (i_state.seq)
            fbcd_pkg::SEQ_ONCE: begin
                if (other_foot) begin
                    upd.seq = fbcd_pkg::SEQ_TWICE;
                end
            end
            fbcd_pkg::SEQ_TWICE: begin
                if (other_foot) begin
                    upd.last_time  = i_now;
                    upd.side       = fbcd_pkg::SIDE_NONE;
                    upd.seq        = fbcd_pkg::SEQ_WAIT;
                    upd.begin_time = '0;
                end
            end
            default: begin
                upd.seq = fbcd_pkg::SEQ_WAIT;
                if (side != fbcd_pkg::SIDE_NONE) begin
                    upd.begin_time = side_time;
                    upd.seq        = fbcd_pkg::SEQ_ONCE;
                end
            end
        endcase
    end

    assign new_age = i_now - upd.begin_time;

    always_comb begin
        o_state = upd;
        // sequence timed out
        if ((upd.seq != fbcd_pkg::SEQ_WAIT) && (new_age > hold_state_ext)) begin
            o_state.side       = fbcd_pkg::SIDE_NONE;
            o_state.seq        = fbcd_pkg::SEQ_WAIT;
            o_state.begin_time = '0;
        end
        o_state.prev_side = o_state.side;

        o_result.result_valid      = 1'b1;
        o_result.collision         = ((i_now - upd.last_time)
                                     < {{(fbcd_pkg::TIME_W-fbcd_pkg::HOLD_W){1'b0}},
                                        i_hold_collision});
        o_result.collision_time_ms = upd.last_time;

        // damaged bumper: state holds, result zeroed
        if (i_damaged) begin
            o_state  = i_state;
            o_result = '0;
        end
    end

endmodule

/* rtl/foot_bumper_collision_detector.sv */
// foot_bumper_collision_detector: top level, input and result registers, config
// depends on fbcd_pkg and fbcd_update
//
// usage:
//   input channel: i_valid / o_stall carries one word per sensor period: the
//   four foot bumper switches, the damaged mask and the current time in ms
//   output channel: o_valid / i_stall carries one result word per input word:
//   result_valid, collision flag and time of the last collision
//   config port: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 hold_state_ms, 1 hold_collision_ms); write only while idle
//   latency: 2 cycles from input accept to o_valid (input register, then
//   the update logic into the result register)
//   throughput: one word per cycle; the whole update is one pass of
//   subtract/compare logic between the input and result registers
//   reset (synchronous, active low): both registers empty, sequencer in
//   wait, sides none, all times zero, holds back to 300 and 1000 ms
//   stall: a held result keeps its payload; one more word waits in the
//   input register, after which o_stall rises until the result is taken

module foot_bumper_collision_detector #(
    parameter int unsigned NUM_BUMPERS = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_left_foot_left_switch,
    input  logic                                  i_left_foot_right_switch,
    input  logic                                  i_right_foot_left_switch,
    input  logic                                  i_right_foot_right_switch,
    input  logic [fbcd_pkg::SWITCH_N-1:0]         i_damaged_mask,
    input  logic [fbcd_pkg::TIME_W-1:0]           i_now_ms,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_result_valid,
    output logic                                  o_collision,
    output logic [fbcd_pkg::TIME_W-1:0]           o_collision_time_ms,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [fbcd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fbcd_pkg::HOLD_W-1:0]           i_cfg_data
);

    // input register
    logic                              r_in_valid;
    logic                              r_in_left;
    logic                              r_in_right;
    logic                              r_in_damaged;
    logic [fbcd_pkg::TIME_W-1:0]       r_in_now;

    // detector state and result register
    fbcd_pkg::t_state                  r_state;
    fbcd_pkg::t_state                  n_state;
    fbcd_pkg::t_result                 r_out;
    fbcd_pkg::t_result                 n_out;
    logic                              r_out_valid;

    logic [fbcd_pkg::HOLD_W-1:0]       r_hold_state;
    logic [fbcd_pkg::HOLD_W-1:0]       r_hold_collision;

    logic                              damaged;
    logic                              in_accept;
    logic                              advance;

    // only the low NUM_BUMPERS mask bits count
    always_comb begin
        damaged = 1'b0;
        for (int i = 0; i < fbcd_pkg::SWITCH_N; i++) begin
            if (i < NUM_BUMPERS) begin
                damaged = damaged | i_damaged_mask[i];
            end
        end
    end

    // the word in the input register moves on unless a result is held
    assign advance   = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall   = r_in_valid && r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_left    <= i_left_foot_left_switch | i_left_foot_right_switch;
            r_in_right   <= i_right_foot_left_switch | i_right_foot_right_switch;
            r_in_damaged <= damaged;
            r_in_now     <= i_now_ms;
        end
    end

    fbcd_update u_update (
        .i_state          (r_state),
        .i_left           (r_in_left),
        .i_right          (r_in_right),
        .i_damaged        (r_in_damaged),
        .i_now            (r_in_now),
        .i_hold_state     (r_hold_state),
        .i_hold_collision (r_hold_collision),
        .o_state          (n_state),
        .o_result         (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.seq        <= fbcd_pkg::SEQ_WAIT;
            r_state.side       <= fbcd_pkg::SIDE_NONE;
            r_state.prev_side  <= fbcd_pkg::SIDE_NONE;
            r_state.side_time  <= '0;
            r_state.begin_time <= '0;
            r_state.last_time  <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register with its valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_state     <= fbcd_pkg::HOLD_STATE_RST;
            r_hold_collision <= fbcd_pkg::HOLD_COLLISION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fbcd_pkg::CFG_HOLD_STATE:     r_hold_state     <= i_cfg_data;
                fbcd_pkg::CFG_HOLD_COLLISION: r_hold_collision <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_valid             = r_out_valid;
    assign o_result_valid      = r_out.result_valid;
    assign o_collision         = r_out.collision;
    assign o_collision_time_ms = r_out.collision_time_ms;

endmodule

/* rtl/fbcd_checker.sv */
// fbcd_port_checks: port-level assertions for the collision detector, bound to the top
// depends on foot_bumper_collision_detector (bind target)

module fbcd_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_result_valid,
    input logic        o_collision,
    input logic [31:0] o_collision_time_ms
);

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a suspended period reports no collision data
    a_damaged_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result_valid) |-> (!o_collision && (o_collision_time_ms == 32'd0)))
        else $error("damaged result carries collision data");

    // input backpressure only comes from a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // a held result keeps its word
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_valid)
                                  && $stable(o_collision) && $stable(o_collision_time_ms)))
        else $error("held result changed");

endmodule

bind foot_bumper_collision_detector fbcd_port_checks u_fbcd_port_checks (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_result_valid      (o_result_valid),
    .o_collision         (o_collision),
    .o_collision_time_ms (o_collision_time_ms)
);
